### hw/rtl/ppdh_pkg.sv
`timescale 1ns / 1ps

package ppdh_pkg;

    localparam int COORD_W   = 20;
    localparam int REQ_W     = 2;
    localparam int BIN_NUM_W = 10;
    localparam int COUNT_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int D2_W      = 42;
    localparam int ROOT_W    = 21;
    localparam int REM_W     = 22;
    localparam int SUB_W     = 24;

    localparam logic [BIN_NUM_W-1:0] BIN_NUM_MAX = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_W = 2'd3;

    localparam logic [COORD_W-1:0] BOX_LEN_RST = 20'd163840;
    localparam logic [COORD_W-1:0] BIN_W_RST   = 20'd82;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } t_point;

    typedef struct packed {
        logic [COORD_W-1:0] len_x;
        logic [COORD_W-1:0] len_y;
        logic [COORD_W-1:0] len_z;
        logic [COORD_W-1:0] bin_w;
    } t_cfg;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] quot;
    } t_core_res;

endpackage

### hw/rtl/ppdh_hist_mem.sv
`timescale 1ns / 1ps

module ppdh_hist_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [ppdh_pkg::COUNT_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [ppdh_pkg::COUNT_W-1:0] o_rdata
);

    logic [ppdh_pkg::COUNT_W-1:0] r_mem [DEPTH];
    logic [ppdh_pkg::COUNT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ppdh_core.sv
`timescale 1ns / 1ps

module ppdh_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ppdh_pkg::t_point    i_first,
    input  ppdh_pkg::t_point    i_second,
    input  ppdh_pkg::t_cfg      i_cfg,
    output ppdh_pkg::t_core_res o_res
);

    typedef enum logic [6:0] {
        C_IDLE = 7'b0000001,
        C_FOLD = 7'b0000010,
        C_MUL  = 7'b0000100,
        C_ACC  = 7'b0001000,
        C_SQRT = 7'b0010000,
        C_DIV  = 7'b0100000,
        C_DONE = 7'b1000000
    } t_cstate;

    localparam logic [4:0] LAST_STEP = 5'(ppdh_pkg::ROOT_W - 1);
    localparam logic [1:0] LAST_AXIS = 2'd2;

    t_cstate r_state, n_state;
    logic [4:0] r_cnt;
    logic [1:0] r_axis;

    ppdh_pkg::t_point r_first, r_second;
    logic [ppdh_pkg::COORD_W-1:0] r_len_x, r_len_y, r_len_z, r_w;
    logic [ppdh_pkg::COORD_W-1:0] r_mag;
    logic [2*ppdh_pkg::COORD_W-1:0] r_prod;
    logic [ppdh_pkg::D2_W-1:0] r_d2;
    logic [ppdh_pkg::REM_W-1:0] r_rem;
    logic [ppdh_pkg::ROOT_W-1:0] r_root, r_q;

    // minimum-image fold of the current axis
    logic [ppdh_pkg::COORD_W-1:0] fa, fb, fl, fold_mag;
    logic signed [22:0] fd, f2d, fL, fr, fneg;
    logic [2*ppdh_pkg::COORD_W-1:0] sq;
    logic [ppdh_pkg::D2_W-1:0] acc_sum;

    always_comb begin
        case (r_axis)
            2'd0: begin
                fa = r_first.x;
                fb = r_second.x;
                fl = r_len_x;
            end
            2'd1: begin
                fa = r_first.y;
                fb = r_second.y;
                fl = r_len_y;
            end
            default: begin
                fa = r_first.z;
                fb = r_second.z;
                fl = r_len_z;
            end
        endcase
        fd  = $signed({3'b000, fa}) - $signed({3'b000, fb});
        f2d = fd <<< 1;
        fL  = $signed({3'b000, fl});
        if (f2d >= fL) begin
            fr = fd - fL;
        end else if (f2d < -fL) begin
            fr = fd + fL;
        end else begin
            fr = fd;
        end
        fneg     = -fr;
        fold_mag = fr[22] ? fneg[ppdh_pkg::COORD_W-1:0] : fr[ppdh_pkg::COORD_W-1:0];
    end

    assign sq      = r_mag * r_mag;
    assign acc_sum = r_d2 + {2'b00, r_prod};

    // shared subtractor: root digit trial in SQRT, quotient digit trial in DIV
    logic [ppdh_pkg::SUB_W-1:0] sub_a, sub_b;
    logic [ppdh_pkg::SUB_W:0]   diff;
    logic                       neg;

    always_comb begin
        case (r_state)
            C_SQRT: begin
                sub_a = {r_rem, r_d2[ppdh_pkg::D2_W-1 -: 2]};
                sub_b = {1'b0, r_root, 2'b01};
            end
            C_DIV: begin
                sub_a = {3'b000, r_rem[ppdh_pkg::COORD_W-1:0],
                         r_root[ppdh_pkg::ROOT_W-1]};
                sub_b = {4'b0000, r_w};
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        neg  = diff[ppdh_pkg::SUB_W];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            C_IDLE: if (i_start) n_state = C_FOLD;
            C_FOLD: n_state = C_MUL;
            C_MUL:  n_state = C_ACC;
            C_ACC:  n_state = (r_axis == LAST_AXIS) ? C_SQRT : C_FOLD;
            C_SQRT: if (r_cnt == LAST_STEP) n_state = C_DIV;
            C_DIV:  if (r_cnt == LAST_STEP) n_state = C_DONE;
            C_DONE: n_state = C_IDLE;
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_cnt   <= '0;
            r_axis  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                C_IDLE: begin
                    r_cnt  <= '0;
                    r_axis <= '0;
                end
                C_ACC: r_axis <= r_axis + 2'd1;
                C_SQRT, C_DIV: r_cnt <= (r_cnt == LAST_STEP) ? 5'd0 : r_cnt + 5'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                r_first  <= i_first;
                r_second <= i_second;
                r_len_x  <= i_cfg.len_x;
                r_len_y  <= i_cfg.len_y;
                r_len_z  <= i_cfg.len_z;
                // zero width counts as one
                r_w      <= (i_cfg.bin_w == '0) ? 20'd1 : i_cfg.bin_w;
                r_d2     <= '0;
                r_rem    <= '0;
                r_root   <= '0;
            end
            C_FOLD: r_mag  <= fold_mag;
            C_MUL:  r_prod <= sq;
            C_ACC:  r_d2   <= acc_sum;
            C_SQRT: begin
                r_d2   <= r_d2 << 2;
                r_root <= {r_root[ppdh_pkg::ROOT_W-2:0], ~neg};
                if (r_cnt == LAST_STEP) begin
                    r_rem <= '0;
                    r_q   <= '0;
                end else begin
                    r_rem <= neg ? sub_a[ppdh_pkg::REM_W-1:0] : diff[ppdh_pkg::REM_W-1:0];
                end
            end
            C_DIV: begin
                // root shifts out MSB first as the dividend
                r_root <= r_root << 1;
                r_rem  <= neg ? ppdh_pkg::REM_W'(sub_a[ppdh_pkg::COORD_W-1:0])
                              : ppdh_pkg::REM_W'(diff[ppdh_pkg::COORD_W-1:0]);
                r_q    <= {r_q[ppdh_pkg::ROOT_W-2:0], ~neg};
            end
            default: ;
        endcase
    end

    assign o_res.done = (r_state == C_DONE);
    assign o_res.quot = r_q;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == C_IDLE)
        else $error("core started while working");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done |=> !o_res.done)
        else $error("core done held");
    a_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == C_SQRT) |-> r_cnt == 5'd0)
        else $error("root step count not cleared");
`endif

endmodule

### hw/rtl/periodic_pair_distance_histogram.sv
`timescale 1ns / 1ps

// Channel   Handshake          Payload
// request   start / busy       i_req_type, i_first_*, i_second_*, i_read_bin
// result    o_done (1 cycle)   o_bin_number, o_was_counted, o_bin_value
// config    i_cfg_we           i_cfg_idx, i_cfg_wdata
//
// Add pair: after accept, 3 x 3 fold/square/accumulate steps, 21 root
// steps and 21 quotient steps on one shared subtractor, then histogram read-modify-write.
// Read: the bin is read from the histogram memory. Clear: one bin per cycle through the single write port.
// After reset a clearing pass runs with busy high; config writes go through.
// o_done is a one-cycle strobe; the receiver cannot stall it.
module periodic_pair_distance_histogram #(
    parameter int NUM_BINS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [19:0] i_first_x,
    input  logic [19:0] i_first_y,
    input  logic [19:0] i_first_z,
    input  logic [19:0] i_second_x,
    input  logic [19:0] i_second_y,
    input  logic [19:0] i_second_z,
    input  logic [9:0]  i_read_bin,
    output logic        o_done,
    output logic [9:0]  o_bin_number,
    output logic        o_was_counted,
    output logic [31:0] o_bin_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [19:0] i_cfg_wdata
);

    localparam int AW = $clog2(NUM_BINS);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CORE  = 6'b000100,
        S_RD    = 6'b001000,
        S_UPD   = 6'b010000,
        S_RDOUT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    logic          r_clr_emit;
    logic          clr_last;

    ppdh_pkg::t_cfg r_cfg;
    logic [ppdh_pkg::ROOT_W-1:0]    r_bin;
    logic [ppdh_pkg::BIN_NUM_W-1:0] r_rb;
    logic                           r_rb_ok;

    logic r_done, r_counted;
    logic n_done;
    logic [ppdh_pkg::BIN_NUM_W-1:0] r_bin_num;
    logic [ppdh_pkg::COUNT_W-1:0]   r_value;

    logic accept, core_start, in_range;
    ppdh_pkg::t_point    first_pt, second_pt;
    ppdh_pkg::t_core_res core_res;

    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [ppdh_pkg::COUNT_W-1:0] mem_wdata, mem_rdata, inc_val;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign core_start = accept && (i_req_type == ppdh_pkg::REQ_ADD);
    assign clr_last   = (r_clr_addr == AW'(NUM_BINS - 1));
    assign in_range   = (32'(r_bin) < 32'(NUM_BINS));
    assign inc_val    = (mem_rdata == ppdh_pkg::COUNT_MAX) ? mem_rdata : mem_rdata + 32'd1;

    assign first_pt  = '{x: i_first_x, y: i_first_y, z: i_first_z};
    assign second_pt = '{x: i_second_x, y: i_second_y, z: i_second_z};

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len_x <= ppdh_pkg::BOX_LEN_RST;
            r_cfg.len_y <= ppdh_pkg::BOX_LEN_RST;
            r_cfg.len_z <= ppdh_pkg::BOX_LEN_RST;
            r_cfg.bin_w <= ppdh_pkg::BIN_W_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppdh_pkg::CFG_BOX_X: r_cfg.len_x <= i_cfg_wdata;
                ppdh_pkg::CFG_BOX_Y: r_cfg.len_y <= i_cfg_wdata;
                ppdh_pkg::CFG_BOX_Z: r_cfg.len_z <= i_cfg_wdata;
                ppdh_pkg::CFG_BIN_W: r_cfg.bin_w <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    ppdh_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (core_start),
        .i_first  (first_pt),
        .i_second (second_pt),
        .i_cfg    (r_cfg),
        .o_res    (core_res)
    );

    always_comb begin
        mem_raddr = (r_state == S_IDLE) ? AW'(i_read_bin) : r_bin[AW-1:0];
        mem_we    = (r_state == S_CLEAR) || ((r_state == S_UPD) && in_range);
        mem_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_bin[AW-1:0];
        mem_wdata = (r_state == S_CLEAR) ? '0 : inc_val;
    end

    ppdh_hist_mem #(
        .DEPTH (NUM_BINS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (ppdh_pkg::t_req'(i_req_type))
                        ppdh_pkg::REQ_ADD:   n_state = S_CORE;
                        ppdh_pkg::REQ_CLEAR: n_state = S_CLEAR;
                        ppdh_pkg::REQ_READ:  n_state = S_RDOUT;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_CORE:  if (core_res.done) n_state = S_RD;
            S_RD:    n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            S_RDOUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            S_CLEAR: n_done = clr_last && r_clr_emit;
            // unused request code: answer at once with zeros
            S_IDLE:  n_done = accept && i_req_type != ppdh_pkg::REQ_ADD &&
                              i_req_type != ppdh_pkg::REQ_CLEAR &&
                              i_req_type != ppdh_pkg::REQ_READ;
            S_UPD, S_RDOUT: n_done = 1'b1;
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_clr_emit <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= clr_last ? '0 : r_clr_addr + AW'(1);
                    if (clr_last) begin
                        r_clr_emit <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (accept && i_req_type == ppdh_pkg::REQ_CLEAR) begin
                        r_clr_emit <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rb      <= i_read_bin;
                r_rb_ok   <= (32'(i_read_bin) < 32'(NUM_BINS));
                r_bin_num <= '0;
                r_counted <= 1'b0;
                r_value   <= '0;
            end
            S_CLEAR: begin
                r_bin_num <= '0;
                r_counted <= 1'b0;
                r_value   <= '0;
            end
            S_CORE: if (core_res.done) r_bin <= core_res.quot;
            S_UPD: begin
                r_bin_num <= (r_bin > ppdh_pkg::ROOT_W'(ppdh_pkg::BIN_NUM_MAX))
                             ? ppdh_pkg::BIN_NUM_MAX : r_bin[ppdh_pkg::BIN_NUM_W-1:0];
                r_counted <= in_range;
                r_value   <= in_range ? inc_val : '0;
            end
            S_RDOUT: begin
                r_bin_num <= r_rb;
                r_counted <= 1'b0;
                r_value   <= r_rb_ok ? mem_rdata : '0;
            end
            default: ;
        endcase
    end

    assign o_done        = r_done;
    assign o_bin_number  = r_bin_num;
    assign o_was_counted = r_counted;
    assign o_bin_value   = r_value;

`ifndef SYNTH
    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy || o_done)
        else $error("accepted item neither in work nor answered");
    a_counted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_was_counted |-> o_bin_value != '0)
        else $error("counted bin reads zero");
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_done)
        else $error("result during clearing pass");
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done && busy)
        else $error("result or idle right after reset");
`endif

endmodule

### sim/tb_periodic_pair_distance_histogram.sv
`timescale 1ns / 1ps

module tb_periodic_pair_distance_histogram;
    import ppdh_pkg::*;

    localparam int NUM_BINS      = 1024;
    localparam int COORD_MAX     = (1 << COORD_W) - 1;
    localparam int QUIET_LIMIT   = 10000;
    localparam int TAIL_CYCLES   = 80;
    localparam int HOT_DEPTH     = 32;
    localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]     req;
        t_point               first;
        t_point               second;
        logic [BIN_NUM_W-1:0] read_bin;
    } t_pair_item;

    typedef struct packed {
        logic [BIN_NUM_W-1:0] number;
        logic                 counted;
        logic [COUNT_W-1:0]   value;
    } t_bin_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [1:0]           i_req_type    = '0;
    logic [19:0]          i_first_x     = '0;
    logic [19:0]          i_first_y     = '0;
    logic [19:0]          i_first_z     = '0;
    logic [19:0]          i_second_x    = '0;
    logic [19:0]          i_second_y    = '0;
    logic [19:0]          i_second_z    = '0;
    logic [9:0]           i_read_bin    = '0;
    logic                 o_done;
    logic [9:0]           o_bin_number;
    logic                 o_was_counted;
    logic [31:0]          o_bin_value;
    logic                 i_cfg_we      = 1'b0;
    logic [1:0]           i_cfg_idx     = '0;
    logic [19:0]          i_cfg_wdata   = '0;

    // Histogram copy and register copy used for prediction
    logic [COUNT_W-1:0]   bin_count [0:NUM_BINS-1];
    logic [COORD_W-1:0]   cfg_box_x = BOX_LEN_RST;
    logic [COORD_W-1:0]   cfg_box_y = BOX_LEN_RST;
    logic [COORD_W-1:0]   cfg_box_z = BOX_LEN_RST;
    logic [COORD_W-1:0]   cfg_bin_w = BIN_W_RST;

    t_pair_item           pending_items [$];
    t_bin_result          expected_bins [$];
    int                   hot_bins [$];
    t_pair_item           on_bus;
    int                   items_queued  = 0;
    int                   items_taken   = 0;
    int                   send_idle_pct = 25;
    int                   error_count   = 0;
    int                   quiet_cycles  = 0;

    periodic_pair_distance_histogram #(
        .NUM_BINS(NUM_BINS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_first_z    (i_first_z),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_second_z   (i_second_z),
        .i_read_bin   (i_read_bin),
        .o_done       (o_done),
        .o_bin_number (o_bin_number),
        .o_was_counted(o_was_counted),
        .o_bin_value  (o_bin_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Minimum-image fold, applied once
    function automatic longint fold_diff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b,
                                         logic [COORD_W-1:0] len);
        longint d;
        longint l;
        d = longint'(a) - longint'(b);
        l = longint'(len);
        if (2 * d >= l) begin
            d = d - l;
        end else if (2 * d < -l) begin
            d = d + l;
        end
        return d;
    endfunction

    function automatic logic [ROOT_W-1:0] floor_root(logic [D2_W-1:0] v);
        logic [ROOT_W-1:0] r;
        logic [ROOT_W-1:0] t;
        r = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            t = r | (ROOT_W'(1) << b);
            if (D2_W'(t) * D2_W'(t) <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // Bin index before the range check, from the current register copy
    function automatic logic [ROOT_W-1:0] pair_bin(t_point p, t_point q);
        longint             dx;
        longint             dy;
        longint             dz;
        logic [D2_W-1:0]    d2;
        logic [COORD_W-1:0] w;
        dx = fold_diff(p.x, q.x, cfg_box_x);
        dy = fold_diff(p.y, q.y, cfg_box_y);
        dz = fold_diff(p.z, q.z, cfg_box_z);
        d2 = D2_W'(dx * dx + dy * dy + dz * dz);
        w  = (cfg_bin_w == '0) ? COORD_W'(1) : cfg_bin_w;
        return floor_root(d2) / ROOT_W'(w);
    endfunction

    function automatic t_bin_result predict_bin_result(t_pair_item it);
        t_bin_result       r;
        logic [ROOT_W-1:0] bin;
        r = '0;
        case (it.req)
            REQ_ADD: begin
                bin = pair_bin(it.first, it.second);
                if (bin < NUM_BINS) begin
                    if (bin_count[bin] != COUNT_MAX) begin
                        bin_count[bin] = bin_count[bin] + 1'b1;
                    end
                    r.counted = 1'b1;
                    r.value   = bin_count[bin];
                end
                r.number = (bin > ROOT_W'(BIN_NUM_MAX)) ? BIN_NUM_MAX : bin[BIN_NUM_W-1:0];
            end
            REQ_CLEAR: begin
                for (int i = 0; i < NUM_BINS; i++) begin
                    bin_count[i] = '0;
                end
            end
            REQ_READ: begin
                r.number = it.read_bin;
                r.value  = bin_count[it.read_bin];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_pair_item make_pair(int fx, int fy, int fz, int sx, int sy, int sz);
        t_pair_item it;
        it          = '0;
        it.req      = REQ_ADD;
        it.first.x  = COORD_W'(fx);
        it.first.y  = COORD_W'(fy);
        it.first.z  = COORD_W'(fz);
        it.second.x = COORD_W'(sx);
        it.second.y = COORD_W'(sy);
        it.second.z = COORD_W'(sz);
        return it;
    endfunction

    function automatic t_pair_item make_op(logic [REQ_W-1:0] req, int rb);
        t_pair_item it;
        it          = '0;
        it.req      = req;
        it.read_bin = BIN_NUM_W'(rb);
        return it;
    endfunction

    function automatic logic [COORD_W-1:0] coord_in_box(logic [COORD_W-1:0] len);
        if (len == '0) begin
            return COORD_W'($urandom_range(COORD_MAX, 0));
        end
        return COORD_W'($urandom_range(int'(len) - 1, 0));
    endfunction

    // Offset from base, wrapped back into the box so the fold gets exercised
    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] base,
                                                      logic [COORD_W-1:0] len, int spread);
        longint c;
        longint l;
        c = longint'(base) + longint'($urandom_range(2 * spread, 0)) - longint'(spread);
        l = (len == '0) ? longint'(COORD_MAX) + 1 : longint'(len);
        c = ((c % l) + l) % l;
        return COORD_W'(c);
    endfunction

    function automatic t_pair_item random_item();
        t_pair_item        it;
        int                pick;
        int                spread;
        logic [ROOT_W-1:0] bin;
        it.req      = REQ_W'($urandom_range(3, 0));
        it.first.x  = COORD_W'($urandom_range(COORD_MAX, 0));
        it.first.y  = COORD_W'($urandom_range(COORD_MAX, 0));
        it.first.z  = COORD_W'($urandom_range(COORD_MAX, 0));
        it.second.x = COORD_W'($urandom_range(COORD_MAX, 0));
        it.second.y = COORD_W'($urandom_range(COORD_MAX, 0));
        it.second.z = COORD_W'($urandom_range(COORD_MAX, 0));
        it.read_bin = BIN_NUM_W'($urandom_range(NUM_BINS - 1, 0));
        pick = $urandom_range(99, 0);
        if (pick < 62) begin
            it.req     = REQ_ADD;
            it.first.x = coord_in_box(cfg_box_x);
            it.first.y = coord_in_box(cfg_box_y);
            it.first.z = coord_in_box(cfg_box_z);
            if ($urandom_range(1, 0) == 1) begin
                // keep the distance mostly inside the histogram range
                spread = ((cfg_bin_w == '0) ? 1 : int'(cfg_bin_w)) * 300;
                if (spread > COORD_MAX) begin
                    spread = COORD_MAX;
                end
                it.second.x = near_coord(it.first.x, cfg_box_x, spread);
                it.second.y = near_coord(it.first.y, cfg_box_y, spread);
                it.second.z = near_coord(it.first.z, cfg_box_z, spread);
            end else begin
                it.second.x = coord_in_box(cfg_box_x);
                it.second.y = coord_in_box(cfg_box_y);
                it.second.z = coord_in_box(cfg_box_z);
            end
        end else if (pick < 74) begin
            it.req = REQ_ADD;
        end else if (pick < 92) begin
            it.req = REQ_READ;
            if (hot_bins.size() != 0 && $urandom_range(1, 0) == 1) begin
                it.read_bin = BIN_NUM_W'(hot_bins[$urandom_range(hot_bins.size() - 1, 0)]);
            end
        end else if (pick < 94) begin
            it.req = REQ_CLEAR;
        end else if (pick < 97) begin
            it.req = REQ_RSVD;
        end
        if (it.req == REQ_ADD) begin
            bin = pair_bin(it.first, it.second);
            if (bin < NUM_BINS) begin
                hot_bins.push_back(int'(bin));
                if (hot_bins.size() > HOT_DEPTH) begin
                    void'(hot_bins.pop_front());
                end
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_BOX_X: cfg_box_x = val;
            CFG_BOX_Y: cfg_box_y = val;
            CFG_BOX_Z: cfg_box_z = val;
            CFG_BIN_W: cfg_bin_w = val;
            default: ;
        endcase
    endtask

    task automatic set_config(int lx, int ly, int lz, int w);
        write_reg(CFG_BOX_X, COORD_W'(lx));
        write_reg(CFG_BOX_Y, COORD_W'(ly));
        write_reg(CFG_BOX_Z, COORD_W'(lz));
        write_reg(CFG_BIN_W, COORD_W'(w));
        hot_bins.delete();
    endtask

    // Hold until every item is taken, every result is back and the block is idle
    task automatic drain();
        while (items_taken != items_queued || expected_bins.size() != 0 || busy) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int n_items, int idle_pct);
        send_idle_pct = idle_pct;
        for (int i = 0; i < n_items; i++) begin
            pending_items.push_back(random_item());
        end
        items_queued += n_items;
        drain();
    endtask

    task automatic queue_item(t_pair_item it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Driver: present items from the pending queue, idle at random
    always @(posedge i_clk) begin
        t_pair_item nxt;
        logic       go;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_bins.push_back(predict_bin_result(on_bus));
                items_taken++;
            end
            if (!start || !busy) begin
                go = (pending_items.size() != 0) && ($urandom_range(99, 0) >= send_idle_pct);
                if (go) begin
                    nxt        = pending_items.pop_front();
                    on_bus     = nxt;
                    start      <= 1'b1;
                    i_req_type <= nxt.req;
                    i_first_x  <= nxt.first.x;
                    i_first_y  <= nxt.first.y;
                    i_first_z  <= nxt.first.z;
                    i_second_x <= nxt.second.x;
                    i_second_y <= nxt.second.y;
                    i_second_z <= nxt.second.z;
                    i_read_bin <= nxt.read_bin;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation
    always @(posedge i_clk) begin
        t_bin_result want;
        if (i_rst_n && o_done) begin
            if (expected_bins.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending, bin %0d value %0d",
                                          o_bin_number, o_bin_value));
            end else begin
                want = expected_bins.pop_front();
                if (o_bin_number !== want.number) begin
                    report_mismatch($sformatf("bin_number got %0d expected %0d",
                                              o_bin_number, want.number));
                end
                if (o_was_counted !== want.counted) begin
                    report_mismatch($sformatf("was_counted got %0b expected %0b",
                                              o_was_counted, want.counted));
                end
                if (o_bin_value !== want.value) begin
                    report_mismatch($sformatf("bin_value got %0d expected %0d (bin %0d)",
                                              o_bin_value, want.value, want.number));
                end
            end
        end
    end

    // Watchdog: stop when nothing has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int lmax;
        for (int i = 0; i < NUM_BINS; i++) begin
            bin_count[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // clearing pass after reset runs with busy high
        drain();

        // Directed items at the reset register values
        send_idle_pct = 25;
        queue_item(make_pair(1000, 2000, 3000, 1000, 2000, 3000));
        queue_item(make_pair(0, 0, 0, 0, 0, 0));
        queue_item(make_pair(81920, 0, 0, 0, 0, 0));
        queue_item(make_pair(0, 0, 0, 81920, 0, 0));
        queue_item(make_pair(0, 0, 0, 81921, 0, 0));
        queue_item(make_pair(81920, 18055, 0, 0, 0, 0));
        queue_item(make_pair(81920, 18432, 0, 0, 0, 0));
        queue_item(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0));
        queue_item(make_pair(0, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX));
        queue_item(make_pair(81920, 81920, 81920, 0, 0, 0));
        queue_item(make_op(REQ_READ, 0));
        queue_item(make_op(REQ_READ, 999));
        queue_item(make_op(REQ_READ, 1023));
        queue_item(make_op(REQ_READ, 5));
        queue_item(make_op(REQ_RSVD, 77));
        queue_item(make_op(REQ_CLEAR, 0));
        queue_item(make_op(REQ_READ, 0));
        queue_item(make_op(REQ_READ, 1023));
        queue_item(make_pair(COORD_MAX, 0, COORD_MAX, COORD_MAX, 0, COORD_MAX));
        queue_item(make_op(REQ_READ, 0));
        drain();

        run_phase(250, 25);

        // Widest box on x, degenerate boxes on y and z, zero bin width
        set_config(COORD_MAX, 1, 0, 0);
        run_phase(100, 25);

        lmax = $urandom_range(400000, 40000);
        set_config(lmax, $urandom_range(lmax, 40000), $urandom_range(lmax, 40000),
                   lmax / 1200 + $urandom_range(20, 1));
        run_phase(180, 58);

        set_config(1, 1, 1, COORD_MAX);
        run_phase(100, 58);

        set_config($urandom_range(COORD_MAX, 1), $urandom_range(COORD_MAX, 1),
                   $urandom_range(COORD_MAX, 1), $urandom_range(2000, 1));
        run_phase(120, 0);

        set_config(int'(BOX_LEN_RST), int'(BOX_LEN_RST), int'(BOX_LEN_RST), int'(BIN_W_RST));
        run_phase(100, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_bins.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_bins.size()));
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
